@@ hdl/cdb_pkg.sv @@
// Package for the choice dictionary bit set: action codes, result type and
// controller command/status structs. No dependencies.
`default_nettype none
package cdb_pkg;
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_TEST   = 2'd2;
	localparam logic [1:0] ACT_CHOOSE = 2'd3;

	typedef struct packed {
		logic        present;
		logic [15:0] chosen;
		logic        status;
	} result_t;

	typedef struct packed {
		logic load;
		logic rd_list;
		logic rd_sum;
		logic rd_word;
		logic exec;
		logic fix_list;
	} cmd_t;

	typedef struct packed {
		logic need_fix;
	} sts_t;
endpackage
`default_nettype wire

@@ hdl/cdb_if.sv @@
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing.
`default_nettype none
interface cdb_if #(parameter type T = logic) (input wire logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/choice_dictionary_bitset.sv @@
// Choice dictionary bit set: one result word per request word. A word passes
// through the idle state that takes it, list read, summary read, member read,
// update, and a list repair step when a group empties; a new word is taken
// only in the idle state, while no result is waiting or it is being taken.
// Depends on cdb_pkg, cdb_if, cdb_ctrl and cdb_dp.
`default_nettype none
module choice_dictionary_bitset
	import cdb_pkg::*;
#(
	parameter int WORD_BITS = 64,
	parameter int WORD_COUNT = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	cdb_if.sink      req,
	cdb_if.source    rsp
);
	cmd_t cmd;
	sts_t sts;
	result_t res;
	logic [17:0] rq;

	assign rq = 18'(req.data);
	assign rsp.data = res;

	cdb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .sts(sts), .cmd(cmd)
	);

	cdb_dp #(.WORD_BITS(WORD_BITS), .WORD_COUNT(WORD_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .action(rq[17:16]),
		.element(rq[15:0]), .sts(sts), .res(res)
	);
endmodule
`default_nettype wire

@@ hdl/cdb_ctrl.sv @@
// Controller state machine for the choice dictionary bit set.
// Depends on cdb_pkg.
`default_nettype none
module cdb_ctrl
	import cdb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LIST = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_WORD = 3'd3;
	localparam logic [2:0] ST_EXEC = 3'd4;
	localparam logic [2:0] ST_FIX  = 3'd5;

	logic [2:0] state_q;
	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			ST_LIST: cmd.rd_list = 1'b1;
			ST_SUM:  cmd.rd_sum = 1'b1;
			ST_WORD: cmd.rd_word = 1'b1;
			ST_EXEC: cmd.exec = 1'b1;
			ST_FIX:  cmd.fix_list = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_LIST;
				ST_LIST: state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_WORD;
				ST_WORD: state_q <= ST_EXEC;
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					state_q <= sts.need_fix ? ST_FIX : ST_IDLE;
				end
				ST_FIX:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !out_valid_q || $past(out_ready) || $past(!out_valid_q)) else $error("load");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q) else $error("result lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix_list |-> $past(cmd.exec)) else $error("fix order");
endmodule
`default_nettype wire

@@ hdl/cdb_dp.sv @@
// Datapath for the choice dictionary bit set: member word memory, group
// summary registers, group list and slot stores. Depends on cdb_pkg.
`default_nettype none
module cdb_dp
	import cdb_pkg::*;
#(
	parameter int WORD_BITS = 64,
	parameter int WORD_COUNT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] element,
	output sts_t             sts,
	output result_t          res
);
	localparam int PB = $clog2(WORD_BITS);
	localparam int GROUPS = (WORD_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int GB = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CB = $clog2(GROUPS + 1);
	localparam int AB = $clog2(WORD_COUNT);
	localparam int EW = 17;

	logic [WORD_BITS-1:0] words_mem [WORD_COUNT];
	logic [WORD_BITS-1:0] summ_q [GROUPS];
	logic [GB-1:0]        list_mem [GROUPS];
	logic [GB-1:0]        slot_mem [GROUPS];
	logic [CB-1:0]        count_q;

	logic [1:0]           act_q;
	logic [EW-1:0]        word_q;
	logic [PB-1:0]        pos_q;
	logic [GB-1:0]        grp_q;
	logic                 rng_q;
	logic [WORD_BITS-1:0] sum_q;
	logic [WORD_BITS-1:0] wrd_q;
	logic [GB-1:0]        slot_q;
	logic [GB-1:0]        last_q;
	logic                 fix_q;
	logic [GB-1:0]        fslot_q;
	logic [GB-1:0]        flast_q;
	logic [PB-1:0]        cw_q;
	logic                 cok_q;

	function automatic logic [PB-1:0] first_set(input logic [WORD_BITS-1:0] w);
		logic [PB-1:0] p;
		p = '0;
		for (int i = 0; i < WORD_BITS; i++)
			if (w[i]) p = PB'(WORD_BITS - 1 - i);
		return p;
	endfunction

	function automatic logic [WORD_BITS-1:0] mbit(input logic [PB-1:0] p);
		return {{(WORD_BITS-1){1'b0}}, 1'b1} << (WORD_BITS - 1 - int'(p));
	endfunction

	logic [EW-1:0] w_full;
	logic [PB-1:0] wmod;
	logic [GB-1:0] g_in;
	logic [AB-1:0] waddr;
	logic [AB-1:0] caddr;
	logic          sbit;
	logic [WORD_BITS-1:0] wcur;
	logic [WORD_BITS-1:0] wnew;
	logic [WORD_BITS-1:0] snew;
	result_t       res_d;

	assign w_full = EW'(element / WORD_BITS);
	assign wmod   = word_q[PB-1:0];
	assign g_in   = GB'(w_full / WORD_BITS);
	assign waddr  = word_q[AB-1:0];
	assign caddr  = AB'(grp_q * WORD_BITS + cw_q);
	assign sbit   = |(sum_q & mbit(wmod));
	assign wcur   = sbit ? wrd_q : '0;
	assign sts.need_fix = rng_q && (act_q == ACT_REMOVE) && (count_q != '0) &&
		(sum_q != '0) && (snew == '0);

	always_comb begin
		wnew = wcur;
		snew = sum_q;
		if (act_q == ACT_INSERT) begin
			wnew = wcur | mbit(pos_q);
			snew = sum_q | mbit(wmod);
		end else if (sbit) begin
			wnew = wrd_q & ~mbit(pos_q);
			if (wnew == '0) snew = sum_q & ~mbit(wmod);
		end
	end

	always_comb begin
		res_d = '0;
		if (cmd.exec) begin
			unique case (act_q)
				ACT_INSERT: ;
				ACT_REMOVE: res_d.status = (count_q == '0);
				ACT_TEST:   res_d.present = rng_q && sbit && |(wrd_q & mbit(pos_q));
				ACT_CHOOSE: begin
					if (count_q == '0 || !cok_q) res_d.status = 1'b1;
					else res_d.chosen = 16'(caddr * WORD_BITS + first_set(wrd_q));
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			word_q <= w_full;
			pos_q <= element[PB-1:0];
			grp_q <= g_in;
			rng_q <= w_full < EW'(WORD_COUNT);
		end
		if (cmd.rd_list) begin
			last_q <= list_mem[count_q == '0 ? '0 : GB'(count_q - 1'b1)];
			slot_q <= slot_mem[grp_q];
		end
		if (cmd.rd_sum) begin
			if (act_q == ACT_CHOOSE) begin
				grp_q <= last_q;
				sum_q <= summ_q[last_q];
				cw_q <= first_set(summ_q[last_q]);
				cok_q <= (summ_q[last_q] != '0) &&
					(int'(last_q) * WORD_BITS + int'(first_set(summ_q[last_q])) < WORD_COUNT);
			end else begin
				sum_q <= summ_q[grp_q];
			end
		end
		if (cmd.rd_word) wrd_q <= words_mem[act_q == ACT_CHOOSE ? caddr : waddr];
		if (cmd.exec && rng_q && (act_q == ACT_INSERT ||
				(act_q == ACT_REMOVE && count_q != '0)))
			words_mem[waddr] <= wnew;
		if (cmd.exec) begin
			fslot_q <= (slot_q >= GB'(count_q - 1'b1)) ? GB'(count_q - 1'b1) : slot_q;
			flast_q <= last_q;
		end
		if (cmd.exec && act_q == ACT_INSERT && rng_q && sum_q == '0 && count_q < CB'(GROUPS)) begin
			list_mem[count_q[GB-1:0]] <= grp_q;
			slot_mem[grp_q] <= count_q[GB-1:0];
		end
		if (cmd.fix_list) begin
			list_mem[fslot_q] <= flast_q;
			slot_mem[flast_q] <= fslot_q;
		end
		if (cmd.exec) res <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fix_q <= 1'b0;
			for (int i = 0; i < GROUPS; i++) summ_q[i] <= '0;
		end else begin
			fix_q <= 1'b0;
			if (cmd.exec && rng_q) begin
				if (act_q == ACT_INSERT) begin
					summ_q[grp_q] <= snew;
					if (sum_q == '0 && count_q < CB'(GROUPS)) count_q <= count_q + 1'b1;
				end else if (act_q == ACT_REMOVE && count_q != '0) begin
					summ_q[grp_q] <= snew;
					if (sum_q != '0 && snew == '0) begin
						count_q <= count_q - 1'b1;
						fix_q <= 1'b1;
					end
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(GROUPS)) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		fix_q |-> $past(act_q) == ACT_REMOVE) else $error("fix without remove");
	assert property (@(posedge clk) disable iff (!arst_n)
		fix_q |-> count_q == $past(count_q) - 1'b1) else $error("count step");
endmodule
`default_nettype wire

@@ tb/choice_dictionary_bitset_tb.sv @@
// Testbench for choice_dictionary_bitset: drives insert, remove, test and choose words
// with random gaps and stalls, and checks every result against a model of the set.
// Depends on cdb_pkg, cdb_if and choice_dictionary_bitset.
`timescale 1ns / 1ps
module choice_dictionary_bitset_tb;
	import cdb_pkg::*;

	localparam int WBITS = 64;
	localparam int WCOUNT = 1024;
	localparam int NGROUPS = (WCOUNT + WBITS - 1) / WBITS;
	localparam int NUM_RANDOM = 600;
	localparam int IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] element;
	} req_word_t;

	class set_scoreboard;
		logic [WBITS-1:0] words [WCOUNT];
		logic [WBITS-1:0] summary [NGROUPS];
		int unsigned      glist [NGROUPS];
		int unsigned      gslot [NGROUPS];
		int unsigned      gcount;
		result_t          pending [$];
		int               failures;
		int               checked;

		function new();
			for (int i = 0; i < WCOUNT; i++) words[i] = '0;
			for (int i = 0; i < NGROUPS; i++) begin
				summary[i] = '0;
				glist[i] = 0;
				gslot[i] = 0;
			end
			gcount = 0;
			failures = 0;
			checked = 0;
		endfunction

		function int unsigned lowest_pos(logic [WBITS-1:0] w);
			for (int p = 0; p < WBITS; p++)
				if (w[WBITS-1-p]) return p;
			return 0;
		endfunction

		function void note(logic [1:0] act, logic [15:0] elem);
			result_t     r;
			int unsigned wi, pos, g, sp, slot, last, cw;
			wi = elem / WBITS;
			pos = elem % WBITS;
			g = wi / WBITS;
			sp = WBITS - 1 - (wi % WBITS);
			r = '0;
			case (act)
				ACT_INSERT: begin
					if (wi < WCOUNT) begin
						if (!summary[g][sp]) begin
							words[wi] = '0;
							if (summary[g] == '0 && gcount < NGROUPS) begin
								glist[gcount] = g;
								gslot[g] = gcount;
								gcount++;
							end
							summary[g][sp] = 1'b1;
						end
						words[wi][WBITS-1-pos] = 1'b1;
					end
				end
				ACT_REMOVE: begin
					if (gcount == 0) begin
						r.status = 1'b1;
					end else if (wi < WCOUNT && summary[g][sp]) begin
						words[wi][WBITS-1-pos] = 1'b0;
						if (words[wi] == '0) begin
							summary[g][sp] = 1'b0;
							if (summary[g] == '0) begin
								slot = gslot[g];
								if (slot >= gcount) slot = gcount - 1;
								last = glist[gcount-1] % NGROUPS;
								glist[slot] = last;
								gslot[last] = slot;
								gcount--;
							end
						end
					end
				end
				ACT_TEST: begin
					if (wi < WCOUNT && summary[g][sp] && words[wi][WBITS-1-pos])
						r.present = 1'b1;
				end
				ACT_CHOOSE: begin
					if (gcount == 0 || gcount > NGROUPS) begin
						r.status = 1'b1;
					end else begin
						g = glist[gcount-1] % NGROUPS;
						cw = g * WBITS + lowest_pos(summary[g]);
						if (summary[g] != '0 && cw < WCOUNT)
							r.chosen = 16'(cw * WBITS + lowest_pos(words[cw]));
						else
							r.status = 1'b1;
					end
				end
			endcase
			pending.push_back(r);
		endfunction

		function void check(result_t got);
			result_t exp_r;
			checked++;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: %p", got);
				failures++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.present !== exp_r.present) begin
				$error("present: expected %0d, got %0d", exp_r.present, got.present);
				failures++;
			end
			if (got.chosen !== exp_r.chosen) begin
				$error("chosen: expected %0d, got %0d", exp_r.chosen, got.chosen);
				failures++;
			end
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	set_scoreboard sb;
	int sent_count;
	int idle_cycles;
	logic [15:0] members [$];

	cdb_if #(.T(req_word_t)) req_ch (clk);
	cdb_if #(.T(result_t)) rsp_ch (clk);

	choice_dictionary_bitset uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.data);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial idle_cycles = 0;

	task automatic send_word(logic [1:0] act, logic [15:0] elem, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.data.action = act;
		req_ch.data.element = elem;
		do @(posedge clk); while (!req_ch.ready);
		sb.note(act, elem);
		sent_count++;
		if (act == ACT_INSERT) members.push_back(elem);
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	function automatic logic [15:0] pool_element();
		logic [15:0] e;
		int unsigned wsel, bsel;
		wsel = $urandom_range(0, 2);
		bsel = $urandom_range(0, 3);
		e[15:12] = 4'($urandom_range(0, NGROUPS - 1));
		e[11:6] = wsel == 0 ? 6'd0 : (wsel == 1 ? 6'd1 : 6'd63);
		e[5:0] = bsel == 0 ? 6'd0 : (bsel == 1 ? 6'd1 : (bsel == 2 ? 6'd63 : 6'($urandom)));
		return e;
	endfunction

	initial begin
		int  sel, idx;
		bit  burst;
		logic [1:0]  act;
		logic [15:0] elem;
		sent_count = 0;
		@(posedge arst_n);
		@(negedge clk);
		send_word(ACT_CHOOSE, 16'd0, 0);
		send_word(ACT_REMOVE, 16'd5, 0);
		send_word(ACT_TEST, 16'd0, 0);
		send_word(ACT_INSERT, 16'd0, 0);
		send_word(ACT_INSERT, 16'hFFFF, 0);
		send_word(ACT_INSERT, 16'hFFFF, 0);
		send_word(ACT_TEST, 16'hFFFF, 0);
		send_word(ACT_TEST, 16'hFFFE, 0);
		send_word(ACT_CHOOSE, 16'hFFFF, 0);
		send_word(ACT_REMOVE, 16'd1234, 0);
		send_word(ACT_INSERT, 16'h8040, 0);
		send_word(ACT_CHOOSE, 16'd0, 0);
		send_word(ACT_REMOVE, 16'hFFFF, 0);
		send_word(ACT_CHOOSE, 16'd0, 0);
		send_word(ACT_REMOVE, 16'h8040, 0);
		send_word(ACT_REMOVE, 16'd0, 0);
		send_word(ACT_CHOOSE, 16'd0, 0);
		send_word(ACT_TEST, 16'd0, 0);
		send_word(ACT_REMOVE, 16'd0, 0);
		members.delete();
		for (int i = 0; i < NUM_RANDOM; i++) begin
			burst = (i % 150) >= 120;
			sel = $urandom_range(0, 99);
			act = sel < 35 ? ACT_INSERT : (sel < 62 ? ACT_REMOVE :
				(sel < 80 ? ACT_TEST : ACT_CHOOSE));
			sel = $urandom_range(0, 99);
			if ((act == ACT_REMOVE || act == ACT_TEST) && members.size() > 0 && sel < 60) begin
				idx = $urandom_range(0, members.size() - 1);
				elem = members[idx];
				if (act == ACT_REMOVE) members.delete(idx);
			end else if (sel < 80) begin
				elem = pool_element();
			end else begin
				elem = 16'($urandom);
			end
			send_word(act, elem, burst);
		end
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d request words and checked %0d results.", sent_count, sb.checked);
		$display("Covered all four actions on empty and populated sets, with gaps and stalls.");
		if (sb.failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		int  gap;
		bit  held;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= 150) begin
				held = 1;
				rsp_ch.ready = 1'b0;
				repeat (300) @(negedge clk);
			end
			gap = ((sb.checked % 200) >= 170) ? 0 : $urandom_range(0, 9);
			rsp_ch.ready = 1'b0;
			repeat (gap) @(negedge clk);
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end
endmodule
